[sv/tmf_pkg.sv]
// Shared types, codes and constants of the per-channel trimmed mean filter.
package tmf_pkg;

  // Fixed field widths
  localparam int CH_W          = 4;
  localparam int RAW_W         = 16;
  localparam int VAL_W         = 12;
  localparam int READING_SHIFT = 4;
  localparam logic [VAL_W-1:0] VAL_MAX = 12'hFFF;

  // Default build sizes
  localparam int DEF_CHANNELS = 8;
  localparam int DEF_SAMPLES  = 8;

  // Entries in the queue between front and back
  localparam int QDEPTH = 2;

  // Input command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Operations handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] reading;
  } job_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } st_t;

endpackage

[sv/tmf_ram.sv]
// Generic simple dual-port RAM with registered read.
module tmf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tmf_front.sv]
// Front end: decodes commands, range-checks the channel, drops no-op items.
module tmf_front import tmf_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [CH_W-1:0]  channel,
  input  logic [RAW_W-1:0] raw_value,
  input  logic             q_ready,
  output logic             q_push,
  output job_t             q_job
);

  logic in_range;
  logic keep;

  assign in_range = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
  assign in_ready = q_ready;

  // Classify the item
  always_comb begin
    q_job.channel = channel;
    q_job.reading = raw_value[READING_SHIFT +: VAL_W];
    q_job.op      = OP_WRITE;
    keep          = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        q_job.op = OP_WRITE;
        keep     = in_range;
      end
      CMD_READ: begin
        q_job.op = in_range ? OP_READ : OP_BAD;
        keep     = 1'b1;
      end
      CMD_CLEAR: begin
        q_job.op = OP_CLEAR;
        keep     = in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && q_ready && keep;

endmodule

[sv/tmf_queue.sv]
// Small register queue of decoded jobs between front and back.
module tmf_queue import tmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic wr_ready,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign wr_ready = count != CW'(QDEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

[sv/tmf_back.sv]
// Back end: history store, insertion sort, middle sum, divide and result register.
module tmf_back import tmf_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int SAMPLES  = DEF_SAMPLES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  filtered_value,
  output logic              bad_channel
);

  localparam int DEPTH     = CHANNELS * SAMPLES;
  localparam int AW        = $clog2(DEPTH);
  localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W     = $clog2(SAMPLES);
  localparam int CNT_W     = $clog2(SAMPLES + 1);
  localparam int SUM_W     = VAL_W + $clog2(SAMPLES);
  localparam int MID_LO    = SAMPLES / 4;
  localparam int MID_N     = SAMPLES - 2 * (SAMPLES / 4);
  localparam int MID_LAST  = MID_LO + MID_N - 1;
  localparam int DIV       = SAMPLES / 2;
  localparam bit DIV_POW2  = (DIV & (DIV - 1)) == 0;
  localparam int DIV_SH    = $clog2(DIV);
  // Reciprocal of the divisor, exact for every SUM_W-bit sum
  localparam int RCP_SH    = SUM_W + $clog2(DIV);
  localparam int RCP_W     = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RCP_SH;
  localparam longint RCP_M = ((longint'(1) << RCP_SH) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_M);

  st_t              state;
  st_t              state_next;
  logic [CHI_W-1:0] ch_idx;
  logic [IDX_W-1:0] fidx;
  logic [IDX_W-1:0] sidx;
  logic             rd_pend;
  logic             rd_ok;
  logic [VAL_W-1:0] sorted [SAMPLES];
  logic [VAL_W-1:0] sorted_next [SAMPLES];
  logic [SUM_W-1:0] sum;
  logic             bad;
  logic [IDX_W-1:0] wp  [CHANNELS];
  logic [CNT_W-1:0] cnt [CHANNELS];

  logic [CHI_W-1:0] job_ch;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             out_load;
  logic [VAL_W-1:0] ins_val;
  logic [SAMPLES-1:0] gt;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0] quot;

  assign job_ch = job.channel[CHI_W-1:0];

  tmf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (job.reading),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          case (job.op)
            OP_READ: state_next = ST_FETCH;
            OP_BAD:  state_next = ST_OUT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (fidx == IDX_W'(SAMPLES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_SUM;
      ST_SUM: begin
        if (sidx == IDX_W'(MID_LAST)) begin
          state_next = DIV_POW2 ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    job_pop   = (state == ST_IDLE) && job_valid;
    ram_we    = job_pop && (job.op == OP_WRITE);
    ram_waddr = AW'(AW'(job_ch) * AW'(SAMPLES) + AW'(wp[job_ch]));
    ram_raddr = AW'(AW'(ch_idx) * AW'(SAMPLES) + AW'(fidx));
    out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  end

  // Parallel insertion of the arriving word into the sorted buffer;
  // entries past the fill count read as zero
  always_comb begin
    ins_val = rd_ok ? ram_rdata : '0;
    for (int j = 0; j < SAMPLES; j++) begin
      gt[j] = sorted[j] > ins_val;
    end
    sorted_next[0] = gt[0] ? ins_val : sorted[0];
    for (int j = 1; j < SAMPLES; j++) begin
      if (!gt[j]) begin
        sorted_next[j] = sorted[j];
      end else if (gt[j-1]) begin
        sorted_next[j] = sorted[j-1];
      end else begin
        sorted_next[j] = ins_val;
      end
    end
  end

  // Divide by the constant divisor: a shift, or one reciprocal multiply
  always_comb begin
    prod = PROD_W'(sum) * PROD_W'(RCP);
    quot = DIV_POW2 ? (sum >> DIV_SH) : sum;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp[c]  <= '0;
        cnt[c] <= '0;
      end
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_FETCH);
      if (job_pop) begin
        case (job.op)
          OP_WRITE: begin
            wp[job_ch] <= (wp[job_ch] == IDX_W'(SAMPLES - 1)) ? '0 : wp[job_ch] + 1'b1;
            if (cnt[job_ch] != CNT_W'(SAMPLES)) begin
              cnt[job_ch] <= cnt[job_ch] + 1'b1;
            end
          end
          OP_CLEAR: begin
            wp[job_ch]  <= '0;
            cnt[job_ch] <= '0;
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          ch_idx <= job_ch;
          fidx   <= '0;
          bad    <= (job.op == OP_BAD);
          sum    <= '0;
          for (int j = 0; j < SAMPLES; j++) begin
            sorted[j] <= VAL_MAX;
          end
        end
      end
      ST_FETCH: begin
        fidx  <= fidx + 1'b1;
        rd_ok <= CNT_W'(fidx) < cnt[ch_idx];
        if (rd_pend) begin
          sorted <= sorted_next;
        end
      end
      ST_DRAIN: begin
        sorted <= sorted_next;
        sidx   <= IDX_W'(MID_LO);
      end
      ST_SUM: begin
        sum  <= sum + SUM_W'(sorted[sidx]);
        sidx <= sidx + 1'b1;
      end
      ST_DIV: begin
        sum <= prod[RCP_SH +: SUM_W];
      end
      ST_OUT: begin
        if (out_load) begin
          filtered_value <= (quot > SUM_W'(VAL_MAX)) ? VAL_MAX : quot[VAL_W-1:0];
          bad_channel    <= bad;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/per_channel_trimmed_mean_filter.sv]
// Per-channel trimmed mean filter: SAMPLES-deep history per channel, mean of sorted middle half.
// Sample and clear items finish at the pop; a read pops its job, makes SAMPLES RAM fetches, a drain
// step, SAMPLES - 2*(SAMPLES/4) summing steps, a reciprocal multiply when SAMPLES/2 is not a power
// of two, and an output load that waits while the held result is not taken. A two-entry job queue
// decouples front and back.
// Synchronous reset clears per-channel fill counts, so every history reads as zero at once.
module per_channel_trimmed_mean_filter import tmf_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int SAMPLES  = DEF_SAMPLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [CH_W-1:0]  channel,
  input  logic [RAW_W-1:0] raw_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] filtered_value,
  output logic             bad_channel
);

  logic q_ready;
  logic q_push;
  job_t q_in;
  logic q_pop;
  logic q_valid;
  job_t q_out;

  // Decode and range check
  tmf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .channel   (channel),
    .raw_value (raw_value),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (q_in)
  );

  // Job queue
  tmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_in),
    .wr_ready (q_ready),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_out)
  );

  // Store, sort and average
  tmf_back #(
    .CHANNELS (CHANNELS),
    .SAMPLES  (SAMPLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job            (q_out),
    .job_pop        (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .bad_channel    (bad_channel)
  );

endmodule
